FILE: rtl/windowed_median_mean_smoother_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef WINDOWED_MEDIAN_MEAN_SMOOTHER_CORE_MACROS_SVH
`define WINDOWED_MEDIAN_MEAN_SMOOTHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WMMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WMMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wmms_pkg.sv
package wmms_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 2'd1;

    localparam int HALF_W = 4;
    localparam logic [HALF_W-1:0] HALF_RESET = 4'd2;

    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_MEAN   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_RANK,
        ST_DIV,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic setup;
        logic rank_start;
        logic div_start;
        logic push;
        logic push_err;
        logic end_set;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic last;
        logic n_lt2;
        logic small_set;
        logic hold;
        logic pend_zero;
        logic emit_ok;
        logic set_mode;
        logic load_done;
        logic rank_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/wmms_channels.sv
interface wmms_in_if #(parameter int SAMPLE_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_in;

    modport source (output valid, sample, last_in, input ready);
    modport sink   (input valid, sample, last_in, output ready);
    modport mon    (input valid, ready, sample, last_in);
endinterface

interface wmms_out_if #(parameter int SAMPLE_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] smoothed;
    logic                           last_out;
    logic                           status;

    modport source (output valid, smoothed, last_out, status, input ready);
    modport sink   (input valid, smoothed, last_out, status, output ready);
    modport mon    (input valid, ready, smoothed, last_out, status);
endinterface

interface wmms_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [wmms_pkg::CFG_IDX_W-1:0]  index;
    logic [wmms_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/windowed_median_mean_smoother_core.sv
// Channel  | Dir | Payload                     | Transaction when
// i_in     | in  | sample, last_in             | i_in.valid & i_in.ready
// o_out    | out | smoothed, last_out, status  | o_out.valid & o_out.ready
// i_cfg    | in  | index, data                 | i_cfg.valid & i_cfg.ready (always ready)
//
// One input transaction at a time: capture runs accept, then decide; then each result
// it releases goes through setup, a window fetch from the history RAM port, then a
// rank scan (median) or a bit-serial divide (mean), and then the hand-off to the
// output register. The window length is at most 2h+1.
// Reset is synchronous, active low; history RAM is not cleared, no sweep.
// A result waiting in the output register stalls the sequencer only when the next
// result is ready to push; the idle state still takes input while it waits.
module windowed_median_mean_smoother_core #(
    parameter int MAX_HALF_WINDOW = 15,
    parameter int SAMPLE_WIDTH    = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wmms_in_if.sink    i_in,
    wmms_out_if.source o_out,
    wmms_cfg_if.sink   i_cfg
);
    wmms_pkg::t_cmd    cmd;
    wmms_pkg::t_status status;

    // sequencer: decides what each result needs and when it may leave
    wmms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // history RAM, window regs, rank scan, accumulator/divider, output reg
    wmms_dp #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );
endmodule

FILE: rtl/wmms_ram.sv
module wmms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/wmms_ctrl.sv
module wmms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wmms_pkg::t_status i_status,
    output wmms_pkg::t_cmd    o_cmd
);
    wmms_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmms_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            wmms_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = wmms_pkg::ST_DECIDE;
                end
            end
            wmms_pkg::ST_DECIDE: begin
                if (i_status.pend_zero) begin
                    o_cmd.end_set = i_status.last;
                    n_state       = wmms_pkg::ST_IDLE;
                end else if (i_status.last && i_status.n_lt2) begin
                    n_state = wmms_pkg::ST_PUSH;
                end else if (i_status.last && i_status.small_set && i_status.hold) begin
                    n_state = wmms_pkg::ST_PUSH;
                end else if (i_status.last || i_status.emit_ok) begin
                    o_cmd.setup = 1'b1;
                    n_state     = wmms_pkg::ST_LOAD;
                end else begin
                    n_state = wmms_pkg::ST_IDLE;
                end
            end
            wmms_pkg::ST_LOAD: begin
                if (i_status.load_done) begin
                    if (i_status.set_mode == wmms_pkg::MODE_MEAN) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = wmms_pkg::ST_DIV;
                    end else begin
                        o_cmd.rank_start = 1'b1;
                        n_state          = wmms_pkg::ST_RANK;
                    end
                end
            end
            wmms_pkg::ST_RANK: begin
                if (i_status.rank_done) begin
                    n_state = wmms_pkg::ST_PUSH;
                end
            end
            wmms_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = wmms_pkg::ST_PUSH;
                end
            end
            wmms_pkg::ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_err = i_status.last && i_status.n_lt2;
                    n_state        = wmms_pkg::ST_DECIDE;
                end
            end
            default: begin
                n_state = wmms_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/wmms_dp.sv
module wmms_dp #(
    parameter int MAX_HALF_WINDOW = 15,
    parameter int SAMPLE_WIDTH    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wmms_in_if.sink           i_in,
    wmms_out_if.source        o_out,
    wmms_cfg_if.sink          i_cfg,
    input  wmms_pkg::t_cmd    i_cmd,
    output wmms_pkg::t_status o_status
);
    localparam int D    = 2 * MAX_HALF_WINDOW + 1;
    localparam int AW   = $clog2(D);
    localparam int CW   = $clog2(2 * D + 1);
    localparam int PW   = $clog2(D + 1);
    localparam int ACW  = SAMPLE_WIDTH + PW;
    localparam int DVW  = ACW + 1;
    localparam int DCW  = $clog2(DVW + 1);
    localparam int HW   = wmms_pkg::HALF_W;

    // config and per-set state
    logic          r_mode;
    logic [HW-1:0] r_hw;
    logic          r_set_mode;
    logic [HW-1:0] r_set_h;
    logic [AW-1:0] r_wr_pos;
    logic [CW-1:0] r_n;
    logic [PW-1:0] r_pend;
    logic          r_last;
    logic          r_hold;

    // window job
    logic [CW-1:0] r_b;
    logic [PW-1:0] r_ld_left;
    logic          r_rd_v;
    logic [PW-1:0] r_cnt;
    logic [PW-1:0] r_pick;
    logic [SAMPLE_WIDTH-1:0] rd_data;

    logic signed [SAMPLE_WIDTH-1:0] r_win [D];
    logic [D-1:0]                   r_lt, r_le;
    logic signed [SAMPLE_WIDTH-1:0] r_cand;
    logic                           r_a_v;
    logic [PW-1:0]                  r_rk_left;
    logic signed [SAMPLE_WIDTH-1:0] r_val;

    logic signed [ACW-1:0] r_acc;
    logic [DVW-1:0]        r_dq;
    logic [CW-1:0]         r_drem;
    logic [DCW-1:0]        r_dv_left;
    logic                  r_dneg;
    logic                  r_dfin;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_smoothed;
    logic                           r_out_last;
    logic                           r_out_status;

    // status terms
    logic [CW-1:0] h_c, two_h, n_m1, d_c, t_med, lo_s, hi_s;
    logic [PW-1:0] pick_s;
    logic          n_ge_w, small_set;
    logic [HW-1:0] h_sat;

    always_comb begin
        h_c       = CW'(r_set_h);
        two_h     = h_c << 1;
        n_m1      = r_n - CW'(1);
        n_ge_w    = (r_n >= two_h + CW'(1));
        small_set = (r_set_mode == wmms_pkg::MODE_MEDIAN) && !n_ge_w;
        d_c       = CW'(r_pend) - CW'(1);
        h_sat     = (int'(r_hw) > MAX_HALF_WINDOW) ? HW'(MAX_HALF_WINDOW) : r_hw;

        t_med = d_c + h_c;
        if (t_med < two_h) begin
            t_med = two_h;
        end
        if (t_med > n_m1) begin
            t_med = n_m1;
        end

        if (small_set) begin
            lo_s   = '0;
            hi_s   = n_m1;
            pick_s = PW'(n_m1 >> 1);
        end else if (r_set_mode == wmms_pkg::MODE_MEAN) begin
            lo_s   = (d_c >= h_c) ? d_c - h_c : '0;
            hi_s   = (d_c + h_c < n_m1) ? d_c + h_c : n_m1;
            pick_s = '0;
        end else begin
            lo_s   = t_med - two_h;
            hi_s   = t_med;
            pick_s = PW'(r_set_h);
        end
    end

    always_comb begin
        o_status.in_valid  = i_in.valid;
        o_status.last      = r_last;
        o_status.n_lt2     = (r_n < CW'(2));
        o_status.small_set = small_set;
        o_status.hold      = r_hold;
        o_status.pend_zero = (r_pend == '0);
        o_status.emit_ok   = ((r_set_mode == wmms_pkg::MODE_MEAN) || n_ge_w)
                             && (CW'(r_pend) > h_c);
        o_status.set_mode  = r_set_mode;
        o_status.load_done = (r_ld_left == '0) && !r_rd_v;
        o_status.rank_done = (r_rk_left == '0) && !r_a_v;
        o_status.div_done  = (r_dv_left == '0) && !r_dfin;
        o_status.out_free  = !r_out_valid || o_out.ready;
    end

    assign i_in.ready     = i_cmd.in_ready;
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_out_valid;
    assign o_out.smoothed = r_out_smoothed;
    assign o_out.last_out = r_out_last;
    assign o_out.status   = r_out_status;

    // ring address of back offset r_b (newest sample is offset 0)
    logic [CW:0]   addr_t;
    logic [AW-1:0] rd_addr;
    always_comb begin
        addr_t = (CW+1)'(r_wr_pos) + (CW+1)'(D - 1) - (CW+1)'(r_b);
        if (addr_t >= (CW+1)'(D)) begin
            addr_t = addr_t - (CW+1)'(D);
        end
        rd_addr = addr_t[AW-1:0];
    end

    wmms_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(D)) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.capture),
        .i_waddr (r_wr_pos),
        .i_wdata (i_in.sample),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= wmms_pkg::MODE_MEDIAN;
            r_hw        <= wmms_pkg::HALF_RESET;
            r_set_mode  <= wmms_pkg::MODE_MEDIAN;
            r_set_h     <= wmms_pkg::HALF_RESET;
            r_wr_pos    <= '0;
            r_n         <= '0;
            r_pend      <= '0;
            r_last      <= 1'b0;
            r_hold      <= 1'b0;
            r_ld_left   <= '0;
            r_rd_v      <= 1'b0;
            r_rk_left   <= '0;
            r_a_v       <= 1'b0;
            r_dv_left   <= '0;
            r_dfin      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == wmms_pkg::REG_MODE) begin
                    r_mode <= i_cfg.data[0];
                end
                if (i_cfg.index == wmms_pkg::REG_HALF_WINDOW) begin
                    r_hw <= i_cfg.data[HW-1:0];
                end
            end

            if (i_cmd.capture) begin
                if (r_n == '0) begin
                    r_set_mode <= r_mode;
                    r_set_h    <= h_sat;
                end
                r_wr_pos <= (r_wr_pos == AW'(D - 1)) ? '0 : r_wr_pos + AW'(1);
                if (r_n < CW'(2 * D)) begin
                    r_n <= r_n + CW'(1);
                end
                if (r_pend < PW'(D)) begin
                    r_pend <= r_pend + PW'(1);
                end
                r_last <= i_in.last_in;
            end

            if (i_cmd.push) begin
                r_pend <= r_pend - PW'(1);
                if (r_last && small_set) begin
                    r_hold <= 1'b1;
                end
            end

            if (i_cmd.end_set) begin
                r_n    <= '0;
                r_pend <= '0;
                r_hold <= 1'b0;
            end

            // window fetch
            if (i_cmd.setup) begin
                r_ld_left <= PW'(hi_s - lo_s) + PW'(1);
                r_rd_v    <= 1'b0;
            end else begin
                r_rd_v <= (r_ld_left != '0);
                if (r_ld_left != '0) begin
                    r_ld_left <= r_ld_left - PW'(1);
                end
            end

            // rank scan
            if (i_cmd.rank_start) begin
                r_rk_left <= r_cnt;
                r_a_v     <= 1'b0;
            end else begin
                r_a_v <= (r_rk_left != '0);
                if (r_rk_left != '0) begin
                    r_rk_left <= r_rk_left - PW'(1);
                end
            end

            // divider sequencing
            if (i_cmd.div_start) begin
                r_dv_left <= DCW'(DVW);
                r_dfin    <= 1'b0;
            end else begin
                r_dfin <= (r_dv_left == DCW'(1));
                if (r_dv_left != '0) begin
                    r_dv_left <= r_dv_left - DCW'(1);
                end
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // rank compare of the head candidate against the whole window
    logic [D-1:0] lt_v, le_v;
    logic [PW-1:0] cnt_lt, cnt_le;
    always_comb begin
        for (int i = 0; i < D; i++) begin
            lt_v[i] = (PW'(i) < r_cnt) && (r_win[i] <  r_win[0]);
            le_v[i] = (PW'(i) < r_cnt) && (r_win[i] <= r_win[0]);
        end
        cnt_lt = PW'($countones(r_lt));
        cnt_le = PW'($countones(r_le));
    end

    // divider step
    logic [ACW-1:0] mag;
    logic [CW:0]    rem_sh, dvsr;
    logic           ge;
    always_comb begin
        mag    = r_acc[ACW-1] ? ACW'(-r_acc) : ACW'(r_acc);
        dvsr   = (CW+1)'(r_cnt) << 1;
        rem_sh = {r_drem, r_dq[DVW-1]};
        ge     = (rem_sh >= dvsr);
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_b    <= lo_s;
            r_cnt  <= PW'(hi_s - lo_s) + PW'(1);
            r_pick <= pick_s;
            r_acc  <= '0;
        end else if (r_ld_left != '0) begin
            r_b <= r_b + CW'(1);
        end

        if (r_rd_v) begin
            r_acc <= r_acc + {{PW{rd_data[SAMPLE_WIDTH-1]}}, rd_data};
            r_win[0] <= rd_data;
            for (int i = 1; i < D; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end else if (r_rk_left != '0) begin
            for (int i = 0; i < D; i++) begin
                if (PW'(i) == r_cnt - PW'(1)) begin
                    r_win[i] <= r_win[0];
                end else if (i < D - 1) begin
                    r_win[i] <= r_win[(i + 1) % D];
                end
            end
        end

        r_lt   <= lt_v;
        r_le   <= le_v;
        r_cand <= r_win[0];
        if (r_a_v && (cnt_lt <= r_pick) && (cnt_le > r_pick)) begin
            r_val <= r_cand;
        end

        if (i_cmd.div_start) begin
            r_dq   <= {mag, 1'b0} + DVW'(r_cnt);
            r_drem <= '0;
            r_dneg <= r_acc[ACW-1];
        end else if (r_dv_left != '0) begin
            r_dq   <= {r_dq[DVW-2:0], ge};
            r_drem <= ge ? CW'(rem_sh - dvsr) : CW'(rem_sh);
        end
        if (r_dfin) begin
            r_val <= r_dneg ? SAMPLE_WIDTH'(~r_dq + DVW'(1)) : SAMPLE_WIDTH'(r_dq);
        end

        if (i_cmd.push) begin
            r_out_smoothed <= i_cmd.push_err ? '0 : r_val;
            r_out_last     <= r_last && (r_pend == PW'(1));
            r_out_status   <= i_cmd.push_err;
        end
    end
endmodule

FILE: rtl/wmms_checker.sv
`include "windowed_median_mean_smoother_core_macros.svh"

module wmms_checker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] i_out_smoothed,
    input logic                    i_out_last,
    input logic                    i_out_status
);
    // error result is always the terminal, zero-valued one
    `WMMS_ASSERT_SAME(a_err_shape, i_clk, i_rst_n, i_out_valid && i_out_status, i_out_smoothed == '0 && i_out_last, "error result not zero/last")

    // one transaction at a time: busy right after taking a sample
    `WMMS_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input ready right after a transaction")

    // stalled result stays offered
    `WMMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output valid dropped while stalled")
endmodule

bind windowed_median_mean_smoother_core wmms_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_wmms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_smoothed (o_out.smoothed),
    .i_out_last     (o_out.last_out),
    .i_out_status   (o_out.status)
);

FILE: test/tb_windowed_median_mean_smoother_core.sv
module tb_windowed_median_mean_smoother_core;
    import wmms_pkg::*;

    localparam int MAX_H    = 15;
    localparam int HIST_D   = 2 * MAX_H + 1;
    localparam int CNT_CAP  = 4095;
    localparam int IDLE_LIM = 50000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;

    typedef struct {
        logic [31:0] smoothed;
        logic        last_out;
        logic        status;
    } t_smooth_res;

    // Golden smoother: history ring plus per-set latched mode and half window.
    class smoother_board;
        longint      ring[HIST_D];
        int          n_seen, n_pend, wr;
        logic        cfg_mode, set_mode;
        int          cfg_h, set_h;
        t_smooth_res pending_q[$];
        int          errors;

        function void reset_state();
            foreach (ring[i]) ring[i] = 0;
            n_seen = 0;
            n_pend = 0;
            wr = 0;
            cfg_mode = MODE_MEDIAN;
            set_mode = MODE_MEDIAN;
            cfg_h = HALF_RESET;
            set_h = HALF_RESET;
            pending_q.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == REG_MODE) cfg_mode = d[0];
            else if (idx == REG_HALF_WINDOW) cfg_h = d;
        endfunction

        function longint at_back(int b);
            return ring[(wr + HIST_D - 1 - b) % HIST_D];
        endfunction

        function longint median_span(int lo, int hi);
            longint buf_s[HIST_D];
            longint x;
            int cnt, k;
            cnt = 0;
            for (int i = lo; i <= hi; i++) begin
                x = at_back(i);
                k = cnt;
                while (k > 0 && buf_s[k-1] > x) begin
                    buf_s[k] = buf_s[k-1];
                    k--;
                end
                buf_s[k] = x;
                cnt++;
            end
            return buf_s[(cnt - 1) / 2];
        endfunction

        // exact mean, nearest with ties away from zero; floor split avoids overflow
        function longint mean_span(int lo, int hi);
            longint c, q, r, qsum, rsum, f, rem;
            c = hi - lo + 1;
            qsum = 0;
            rsum = 0;
            for (int i = lo; i <= hi; i++) begin
                q = at_back(i) / c;
                r = at_back(i) % c;
                if (r < 0) begin
                    q -= 1;
                    r += c;
                end
                qsum += q;
                rsum += r;
            end
            f = qsum + rsum / c;
            rem = rsum % c;
            if (2 * rem > c || (2 * rem == c && f >= 0)) f += 1;
            return f;
        endfunction

        function longint smooth_at(int d);
            int lo, hi;
            if (set_mode == MODE_MEAN) begin
                lo = (d >= set_h) ? d - set_h : 0;
                hi = (d + set_h < n_seen - 1) ? d + set_h : n_seen - 1;
                return mean_span(lo, hi);
            end
            hi = d + set_h;
            if (hi < 2 * set_h) hi = 2 * set_h;
            if (hi > n_seen - 1) hi = n_seen - 1;
            lo = hi - 2 * set_h;
            return median_span(lo, hi);
        endfunction

        function void push_res(longint v, logic l, logic s);
            t_smooth_res e;
            e.smoothed = v[31:0];
            e.last_out = l;
            e.status = s;
            pending_q.push_back(e);
        endfunction

        // accepted input transaction: append whatever results it releases
        function void note_sample(logic signed [31:0] s, logic last);
            longint med;
            int w;
            if (n_seen == 0) begin
                set_mode = cfg_mode;
                set_h = (cfg_h > MAX_H) ? MAX_H : cfg_h;
            end
            ring[wr] = longint'(s);
            wr = (wr + 1) % HIST_D;
            if (n_seen < CNT_CAP) n_seen++;
            if (n_pend < HIST_D) n_pend++;
            w = 2 * set_h + 1;
            if (last) begin
                if (n_seen < 2) push_res(0, 1'b1, 1'b1);
                else if (set_mode == MODE_MEDIAN && n_seen < w) begin
                    med = median_span(0, n_seen - 1);
                    for (int k = n_pend; k > 0; k--) push_res(med, k == 1, 1'b0);
                end else begin
                    for (int k = n_pend; k > 0; k--) push_res(smooth_at(k - 1), k == 1, 1'b0);
                end
                n_seen = 0;
                n_pend = 0;
            end else if (set_mode == MODE_MEAN || n_seen >= w) begin
                while (n_pend > set_h) begin
                    push_res(smooth_at(n_pend - 1), 1'b0, 1'b0);
                    n_pend--;
                end
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] sm, logic lo, logic st);
            t_smooth_res e;
            if (pending_q.size() == 0) begin
                report("unexpected result", sm, 0);
                return;
            end
            e = pending_q.pop_front();
            if (sm !== e.smoothed) report("smoothed", sm, e.smoothed);
            if (lo !== e.last_out) report("last_out", lo, e.last_out);
            if (st !== e.status) report("status", st, e.status);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    smoother_board board = new();

    wmms_in_if  #(.SAMPLE_WIDTH(32)) in_ch();
    wmms_out_if #(.SAMPLE_WIDTH(32)) out_ch();
    wmms_cfg_if                      cfg_ch();

    windowed_median_mean_smoother_core #(
        .MAX_HALF_WINDOW(MAX_H),
        .SAMPLE_WIDTH(32)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.last_in = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    // Receiver: stall style is redrawn at random from open, coin flip, mostly shut.
    int stall_style = 0;
    int stall_cnt = 0;
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready && i_rst_n)
            board.check_result(out_ch.smoothed, out_ch.last_out, out_ch.status);
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 63) stall_style <= $urandom_range(0, 2);
        case (stall_style)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Watchdog: counts cycles with no transaction on any channel.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sender burst state: once a burst runs out, valid may drop for a random gap.
    int burst_left = 0;

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.write_reg(idx, d);
        cfg_ch.valid <= 1'b0;
    endtask

    task send_sample(logic signed [31:0] s, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(posedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.sample <= s;
        in_ch.last_in <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_sample(s, last);
        burst_left--;
        // keep valid high; the next call either overwrites payload or drops it
    endtask

    task drop_valid();
        @(posedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Phase boundary: all results in, plus margin for any result still in flight.
    task drain();
        drop_valid();
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function logic signed [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return S_MAX;
            1: return S_MIN;
            2: return $urandom_range(0, 8) - 4;
            3: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task send_set(int len);
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
    endtask

    int h_now, len, sent;

    initial begin
        board.reset_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, median with reset half window 2.
        send_sample(S_MAX, 1'b1);                 // single-sample set -> error status
        send_sample(S_MIN, 1'b0);                 // shorter than window: lower median
        send_sample(S_MAX, 1'b0);
        send_sample(0, 1'b0);
        send_sample(32'sd7, 1'b1);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? S_MAX : S_MIN, i == 5);
        drain();

        // Directed, mean h=1: rounding ties both signs and extreme sums.
        write_reg(REG_MODE, {3'b000, MODE_MEAN});
        write_reg(REG_HALF_WINDOW, 4'd1);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd2, 1'b1);
        send_sample(-32'sd1, 1'b0);
        send_sample(-32'sd2, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b1);
        send_sample(S_MIN, 1'b1);                 // single-sample set in mean mode
        drain();

        // Spare indexes are ignored by the block.
        write_reg(REG_SPARE_A, 4'hf);
        write_reg(REG_SPARE_B, 4'h5);

        // Random phases: every phase picks settings, some at the extremes.
        sent = 0;
        for (int ph = 0; sent < 260; ph++) begin
            case (ph % 5)
                0: h_now = 0;
                1: h_now = 15;
                default: h_now = $urandom_range(0, 15);
            endcase
            write_reg(REG_MODE, {3'b000, logic'(ph % 2)});
            write_reg(REG_HALF_WINDOW, h_now[3:0]);
            for (int s = 0; s < 4; s++) begin
                case ($urandom_range(0, 9))
                    0: len = 1;
                    1: len = $urandom_range(32, 40);
                    2: len = $urandom_range(2, 2 * h_now + 1);
                    default: len = $urandom_range(2, 2 * h_now + 8);
                endcase
                // a config write mid-set takes effect only with the next set
                send_set(len);
                sent += len;
            end
            drain();
        end

        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
